// ===== rtl/itf_pkg.sv =====
`default_nettype none

package itf_pkg;

  // Widest field the block will pad out to; larger requests saturate here.
  localparam int WIDTH_LIMIT = 64;
  // Byte counters hold WIDTH_LIMIT and also the longest digit string (64).
  localparam int CNT_W = ($clog2(WIDTH_LIMIT + 1) > 7) ? $clog2(WIDTH_LIMIT + 1) : 7;

  localparam int VAL_W      = 64;
  localparam int BCD_DIGITS = 20;
  localparam int DIG_W      = 4 * BCD_DIGITS;
  localparam int NDIG_W     = 7;

  // Conversion kinds
  localparam logic [2:0] CMD_SDEC = 3'd0;
  localparam logic [2:0] CMD_UDEC = 3'd1;
  localparam logic [2:0] CMD_OCT  = 3'd2;
  localparam logic [2:0] CMD_HEXL = 3'd3;
  localparam logic [2:0] CMD_HEXU = 3'd4;
  localparam logic [2:0] CMD_BIN  = 3'd5;

  // Digit window width in the digit shift register
  localparam logic [1:0] DW_1 = 2'd0;
  localparam logic [1:0] DW_3 = 2'd1;
  localparam logic [1:0] DW_4 = 2'd2;

  // Full digit counts of each kind before leading zeros are dropped
  localparam logic [NDIG_W-1:0] ND_DEC = NDIG_W'(BCD_DIGITS);
  localparam logic [NDIG_W-1:0] ND_OCT = NDIG_W'(22);
  localparam logic [NDIG_W-1:0] ND_HEX = NDIG_W'(16);
  localparam logic [NDIG_W-1:0] ND_BIN = NDIG_W'(VAL_W);

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_PLUS    = 8'h2b;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_UPPER_A = 8'h41;

  typedef struct packed {
    logic [2:0]              cmd;
    logic signed [VAL_W-1:0] value;
    logic [6:0]              field_width;
    logic [7:0]              pad_char;
    logic                    left_align;
    logic                    force_sign;
    logic                    precision_given;
  } req_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last;
  } rsp_t;

  // Everything the byte sequencer needs for one field
  typedef struct packed {
    logic [DIG_W-1:0]  digs;
    logic [NDIG_W-1:0] ndig;
    logic [1:0]        dw;
    logic              upper;
    logic              suppress;
    logic              has_sign;
    logic [7:0]        sign_char;
    logic              sign_first;
    logic              left;
    logic [7:0]        pad;
    logic [CNT_W-1:0]  width;
  } emit_load_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    base = upper ? CH_UPPER_A : CH_LOWER_A;
    if (d < 4'd10) return CH_ZERO + {4'b0000, d};
    return base + {4'b0000, d} - 8'd10;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/itf_bcd.sv =====
`default_nettype none

// Bit-serial binary to BCD conversion (shift and add 3), one input bit a cycle.
module itf_bcd (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [itf_pkg::VAL_W-1:0]  bin,
  output logic                       done,
  output logic [itf_pkg::DIG_W-1:0]  bcd
);
  import itf_pkg::*;

  logic [VAL_W-1:0]  sh;
  logic [NDIG_W-1:0] cnt;
  logic [DIG_W-1:0]  adj;

  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= NDIG_W'(VAL_W);
      end else if (cnt != '0) begin
        cnt <= cnt - NDIG_W'(1);
        if (cnt == NDIG_W'(1)) done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= bin;
      bcd <= '0;
    end else if (cnt != '0) begin
      bcd <= {adj[DIG_W-2:0], sh[VAL_W-1]};
      sh  <= {sh[VAL_W-2:0], 1'b0};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/itf_emit.sv =====
`default_nettype none

// Drop leading zero digits, then shift out the field one byte a cycle.
module itf_emit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  itf_pkg::emit_load_t  ld,
  output logic                 strobe,
  output itf_pkg::rsp_t        rsp,
  output logic                 fin
);
  import itf_pkg::*;

  localparam logic [1:0] E_IDLE = 2'd0;
  localparam logic [1:0] E_NORM = 2'd1;
  localparam logic [1:0] E_PLAN = 2'd2;
  localparam logic [1:0] E_RUN  = 2'd3;

  logic [1:0]        state;
  emit_load_t        cfg;
  logic [CNT_W-1:0]  tot;
  logic [CNT_W-1:0]  pre_pads;
  logic [NDIG_W-1:0] dig_cnt;
  logic              sign1;
  logic              sign2;

  logic [3:0]        top_dig;
  logic [DIG_W-1:0]  digs_shifted;
  logic [NDIG_W-1:0] body_len;
  logic [CNT_W-1:0]  body_ext;
  logic              wide;

  always_comb begin
    case (cfg.dw)
      DW_1: begin
        top_dig      = {3'b000, cfg.digs[DIG_W-1]};
        digs_shifted = {cfg.digs[DIG_W-2:0], 1'b0};
      end
      DW_3: begin
        top_dig      = {1'b0, cfg.digs[DIG_W-1 -: 3]};
        digs_shifted = {cfg.digs[DIG_W-4:0], 3'b000};
      end
      default: begin
        top_dig      = cfg.digs[DIG_W-1 -: 4];
        digs_shifted = {cfg.digs[DIG_W-5:0], 4'b0000};
      end
    endcase
    body_len = cfg.suppress ? '0 : cfg.ndig + {{(NDIG_W-1){1'b0}}, cfg.has_sign};
    body_ext = CNT_W'(body_len);
    wide     = cfg.width > body_ext;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= E_IDLE;
      strobe <= 1'b0;
      fin    <= 1'b0;
    end else begin
      strobe <= 1'b0;
      fin    <= 1'b0;
      case (state)
        E_IDLE: begin
          if (load) begin
            cfg   <= ld;
            state <= ld.suppress ? E_PLAN : E_NORM;
          end
        end
        E_NORM: begin
          if (cfg.ndig > NDIG_W'(1) && top_dig == 4'd0) begin
            cfg.digs <= digs_shifted;
            cfg.ndig <= cfg.ndig - NDIG_W'(1);
          end else begin
            state <= E_PLAN;
          end
        end
        E_PLAN: begin
          tot      <= wide ? cfg.width : body_ext;
          pre_pads <= (!cfg.left && wide) ? cfg.width - body_ext : '0;
          dig_cnt  <= cfg.suppress ? '0 : cfg.ndig;
          sign1    <= cfg.has_sign && cfg.sign_first;
          sign2    <= cfg.has_sign && !cfg.sign_first;
          if (!wide && body_len == '0) begin
            state <= E_IDLE;
            fin   <= 1'b1;
          end else begin
            state <= E_RUN;
          end
        end
        E_RUN: begin
          strobe   <= 1'b1;
          rsp.last <= (tot == CNT_W'(1));
          tot      <= tot - CNT_W'(1);
          if (sign1) begin
            rsp.char_out <= cfg.sign_char;
            sign1        <= 1'b0;
          end else if (pre_pads != '0) begin
            rsp.char_out <= cfg.pad;
            pre_pads     <= pre_pads - CNT_W'(1);
          end else if (sign2) begin
            rsp.char_out <= cfg.sign_char;
            sign2        <= 1'b0;
          end else if (dig_cnt != '0) begin
            rsp.char_out <= digit_char(top_dig, cfg.upper);
            cfg.digs     <= digs_shifted;
            dig_cnt      <= dig_cnt - NDIG_W'(1);
          end else begin
            rsp.char_out <= cfg.pad;
          end
          if (tot == CNT_W'(1)) begin
            state <= E_IDLE;
            fin   <= 1'b1;
          end
        end
        default: state <= E_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/integer_text_formatter_unit.sv =====
// Order: on the decimal kinds the BCD conversion runs first, then leading zeros are dropped
//   one at a time (up to 19); the radix kinds only drop leading zeros (up to 21 octal, 15 hex,
//   63 binary); when a precision suppresses the digits, the leading-zero drop is skipped.
// Fields: one at a time; busy holds until the cycle after the last byte; an unknown kind
//   is taken without busy rising.
// Reset: synchronous, active high; returns to idle and drops any field in flight.
// The receiver cannot stall: each byte is shown for exactly one cycle with strobe high.
`default_nettype none

module integer_text_formatter_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  itf_pkg::req_t  req,
  output logic           busy,
  output logic           strobe,
  output itf_pkg::rsp_t  rsp
);
  import itf_pkg::*;

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_PREP = 2'd1;
  localparam logic [1:0] T_CONV = 2'd2;
  localparam logic [1:0] T_EMIT = 2'd3;

  logic [1:0]       state;
  req_t             req_q;

  logic             is_dec;
  logic             neg;
  logic [VAL_W-1:0] raw;
  logic [VAL_W-1:0] mag;
  logic [CNT_W-1:0] fw_ext;
  emit_load_t       ld;
  logic             bcd_start;
  logic             bcd_done;
  logic [DIG_W-1:0] bcd_digs;
  logic             emit_load;
  logic             emit_fin;

  assign busy = (state != T_IDLE);

  // Decode the held request into the field plan.
  always_comb begin
    is_dec = (req_q.cmd == CMD_SDEC) || (req_q.cmd == CMD_UDEC);
    raw    = req_q.value;
    neg    = (req_q.cmd == CMD_SDEC) && raw[VAL_W-1];
    mag    = neg ? (~raw + VAL_W'(1)) : raw;
    fw_ext = CNT_W'(req_q.field_width);

    // Align each radix so its top digit sits at the top of the digit register.
    case (req_q.cmd)
      CMD_OCT: begin
        ld.digs = {2'b00, raw, {(DIG_W-VAL_W-2){1'b0}}};
        ld.ndig = ND_OCT;
        ld.dw   = DW_3;
      end
      CMD_HEXL, CMD_HEXU: begin
        ld.digs = {raw, {(DIG_W-VAL_W){1'b0}}};
        ld.ndig = ND_HEX;
        ld.dw   = DW_4;
      end
      CMD_BIN: begin
        ld.digs = {raw, {(DIG_W-VAL_W){1'b0}}};
        ld.ndig = ND_BIN;
        ld.dw   = DW_1;
      end
      default: begin
        ld.digs = bcd_digs;
        ld.ndig = ND_DEC;
        ld.dw   = DW_4;
      end
    endcase

    ld.upper      = (req_q.cmd == CMD_HEXU);
    ld.suppress   = !is_dec && req_q.precision_given;
    ld.has_sign   = (req_q.cmd == CMD_SDEC) && (neg || req_q.force_sign);
    ld.sign_char  = neg ? CH_MINUS : CH_PLUS;
    // The sign leads the pads when it is part of left-aligned text or when
    // zero padding sits between it and the digits.
    ld.sign_first = ld.has_sign && (req_q.left_align || req_q.pad_char == CH_ZERO);
    // Left-aligned decimal pads with spaces rather than trailing zeros.
    ld.pad        = (is_dec && req_q.left_align && req_q.pad_char == CH_ZERO) ?
                    CH_SPACE : req_q.pad_char;
    ld.left       = req_q.left_align;
    ld.width      = (fw_ext > CNT_W'(WIDTH_LIMIT)) ? CNT_W'(WIDTH_LIMIT) : fw_ext;
  end

  assign bcd_start = (state == T_PREP) && is_dec;
  assign emit_load = ((state == T_PREP) && !is_dec) || ((state == T_CONV) && bcd_done);

  // Request sequencing: hold the transfer, convert when decimal, then hand off
  // to the byte sequencer and wait for its final byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
    end else begin
      case (state)
        T_IDLE: begin
          // Drop unknown kinds: they produce no bytes.
          if (start && req.cmd <= CMD_BIN) state <= T_PREP;
        end
        T_PREP: state <= is_dec ? T_CONV : T_EMIT;
        T_CONV: begin
          if (bcd_done) state <= T_EMIT;
        end
        T_EMIT: begin
          if (emit_fin) state <= T_IDLE;
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) req_q <= req;
  end

  itf_bcd u_bcd (
    .clk   (clk),
    .rst   (rst),
    .start (bcd_start),
    .bin   (mag),
    .done  (bcd_done),
    .bcd   (bcd_digs)
  );

  itf_emit u_emit (
    .clk    (clk),
    .rst    (rst),
    .load   (emit_load),
    .ld     (ld),
    .strobe (strobe),
    .rsp    (rsp),
    .fin    (emit_fin)
  );

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import itf_pkg::*;

  // Cycles without any transfer, in or out, before the run is abandoned.
  localparam int STALL_LIMIT = 3000;
  // Cycles to keep watching after the last expected byte. This covers a field
  // that makes no bytes but may still be in conversion.
  localparam int DRAIN_CYCLES = 200;
  localparam int RANDOM_FIELDS = 105;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  start = 1'b0;
  req_t  req = '0;
  logic  busy;
  logic  strobe;
  rsp_t  rsp;

  // Bytes still owed by the block, oldest first
  rsp_t  field_bytes[$];

  int    mismatches = 0;
  int    bytes_checked = 0;
  int    fields_sent = 0;
  int    ignored_sent = 0;
  int    burst_left = 0;
  int    idle_cycles = 0;

  integer_text_formatter_unit u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .req    (req),
    .busy   (busy),
    .strobe (strobe),
    .rsp    (rsp)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Build the byte sequence of one field and queue it behind earlier fields.
  function automatic void predict_field(input req_t r);
    logic [7:0] text[$];
    logic [7:0] seq[$];
    logic [63:0] mag;
    logic [63:0] mask;
    logic [3:0]  nib;
    logic [7:0]  pad;
    int          width;
    int          shift;
    int          body_len;
    int          npad;
    int          pos;
    bit          neg;
    bit          has_sign;
    rsp_t        b;

    width = (r.field_width > WIDTH_LIMIT) ? WIDTH_LIMIT : int'(r.field_width);
    pad = r.pad_char;
    neg = 1'b0;
    has_sign = 1'b0;
    // Kinds past binary are dropped without output.
    if (r.cmd > CMD_BIN) return;

    mag = r.value;
    if (r.cmd == CMD_SDEC || r.cmd == CMD_UDEC) begin
      neg = (r.cmd == CMD_SDEC) && r.value[63];
      // Two's complement negate; the most negative value maps to itself, which
      // as an unsigned magnitude is exactly right.
      if (neg) mag = -mag;
      do begin
        text.push_front(CH_ZERO + 8'(mag % 10));
        mag = mag / 10;
      end while (mag != 0);
      has_sign = (r.cmd == CMD_SDEC) && (neg || r.force_sign);
      if (has_sign) text.push_front(neg ? CH_MINUS : CH_PLUS);
      // Zeros after the digits would change the number, so decimal uses spaces.
      if (r.left_align && pad == CH_ZERO) pad = CH_SPACE;
    end else begin
      shift = (r.cmd == CMD_OCT) ? 3 : (r.cmd == CMD_BIN) ? 1 : 4;
      mask = (64'd1 << shift) - 64'd1;
      do begin
        nib = 4'(mag & mask);
        if (nib < 4'd10) text.push_front(CH_ZERO + nib);
        else text.push_front((r.cmd == CMD_HEXU ? CH_UPPER_A : CH_LOWER_A) + nib - 8'd10);
        mag = mag >> shift;
      end while (mag != 0);
    end

    // A precision on the radix kinds drops every digit; only padding remains.
    body_len = (r.cmd >= CMD_OCT && r.precision_given) ? 0 : text.size();
    npad = (width > body_len) ? width - body_len : 0;
    pos = 0;

    if (!r.left_align) begin
      // The sign leads the zero pads.
      if (has_sign && pad == CH_ZERO) begin
        seq.push_back(text[0]);
        pos = 1;
        body_len--;
      end
      repeat (npad) seq.push_back(pad);
    end
    for (int i = 0; i < body_len; i++) seq.push_back(text[pos + i]);
    if (r.left_align) repeat (npad) seq.push_back(pad);

    foreach (seq[i]) begin
      b.char_out = seq[i];
      b.last = (i == seq.size() - 1);
      field_bytes.push_back(b);
    end
  endfunction

  function automatic void log_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("ERROR: %s", msg);
  endfunction

  function automatic req_t make_req(input logic [2:0] cmd, input logic [63:0] value,
                                    input int width, input logic [7:0] pad,
                                    input bit left, input bit fsign, input bit prec);
    req_t r;
    r.cmd = cmd;
    r.value = value;
    r.field_width = 7'(width);
    r.pad_char = pad;
    r.left_align = left;
    r.force_sign = fsign;
    r.precision_given = prec;
    return r;
  endfunction

  // Present one request and hold it until the block takes it. Call at a rising
  // edge; returns at the edge of the transfer or after the gap that follows.
  task automatic send_item(input req_t r);
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy);
    predict_field(r);
    if (r.cmd > CMD_BIN) ignored_sent++;
    else fields_sent++;
    // Keep start high inside a burst; drop it for a random gap between bursts.
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(0, 4) == 0) ? 120 : 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 5);
    end
  endtask

  // Check every byte the block shows against the oldest outstanding byte.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && strobe) begin
      if (field_bytes.size() == 0) begin
        log_error($sformatf("unexpected byte char %02h last %0b", rsp.char_out, rsp.last));
      end else begin
        want = field_bytes.pop_front();
        bytes_checked++;
        if (rsp.char_out !== want.char_out || rsp.last !== want.last)
          log_error($sformatf("byte %0d: expected char %02h last %0b, got char %02h last %0b",
                              bytes_checked, want.char_out, want.last,
                              rsp.char_out, rsp.last));
      end
    end
  end

  // Abort if neither side transfers for too long.
  always @(posedge clk) begin
    if ((start && !busy) || strobe) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Signs, zero padding order, extremes of the decimal kinds.
  task automatic test_decimal_kinds();
    send_item(make_req(CMD_SDEC, 64'd0, 0, CH_SPACE, 0, 0, 0));
    send_item(make_req(CMD_SDEC, 64'h8000_0000_0000_0000, 0, CH_SPACE, 0, 0, 0));
    send_item(make_req(CMD_SDEC, 64'h7fff_ffff_ffff_ffff, 0, CH_SPACE, 0, 1, 0));
    send_item(make_req(CMD_SDEC, -64'sd42, 10, CH_ZERO, 0, 0, 0));
    send_item(make_req(CMD_SDEC, 64'd42, 8, CH_ZERO, 0, 1, 0));
    send_item(make_req(CMD_SDEC, -64'sd7, 6, CH_ZERO, 1, 0, 0));
    send_item(make_req(CMD_SDEC, -64'sd1, 64, CH_ZERO, 0, 1, 0));
    send_item(make_req(CMD_SDEC, 64'd0, 127, "x", 1, 0, 0));
    send_item(make_req(CMD_UDEC, 64'hffff_ffff_ffff_ffff, 25, "*", 0, 1, 0));
    send_item(make_req(CMD_UDEC, 64'd123, 10, CH_ZERO, 1, 0, 1));
    send_item(make_req(CMD_UDEC, 64'd9, 3, 8'h00, 0, 0, 0));
  endtask

  // Every radix kind, the widest text, width saturation, zeros kept after.
  task automatic test_radix_kinds();
    send_item(make_req(CMD_OCT, 64'hffff_ffff_ffff_ffff, 0, CH_SPACE, 0, 0, 0));
    send_item(make_req(CMD_OCT, 64'd8, 5, CH_ZERO, 1, 1, 0));
    send_item(make_req(CMD_HEXL, 64'hdead_beef_cafe_f00d, 0, CH_SPACE, 0, 0, 0));
    send_item(make_req(CMD_HEXU, 64'hdead_beef_cafe_f00d, 20, CH_ZERO, 0, 1, 0));
    send_item(make_req(CMD_BIN, 64'hffff_ffff_ffff_ffff, 0, CH_SPACE, 0, 0, 0));
    send_item(make_req(CMD_BIN, 64'd5, 127, ".", 1, 0, 0));
    send_item(make_req(CMD_BIN, 64'd0, 1, 8'hff, 0, 0, 0));
  endtask

  // Suppressed digits, with and without width, and unknown kinds.
  task automatic test_suppressed_and_ignored();
    send_item(make_req(CMD_HEXL, 64'h1234, 0, CH_SPACE, 0, 0, 1));
    send_item(make_req(CMD_OCT, 64'h1234, 12, "#", 0, 0, 1));
    send_item(make_req(CMD_BIN, 64'h1, 3, CH_ZERO, 1, 0, 1));
    send_item(make_req(3'd6, 64'd77, 10, CH_ZERO, 0, 1, 0));
    send_item(make_req(3'd7, 64'd77, 10, CH_ZERO, 1, 0, 1));
  endtask

  // Random requests; mostly small widths, every field bit toggled.
  task automatic test_random_fields();
    req_t r;
    int   k;
    int   counted;
    counted = 0;
    while (counted < RANDOM_FIELDS) begin
      r.cmd = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      k = $urandom_range(0, 63);
      case ($urandom_range(0, 5))
        0: r.value = {$urandom, $urandom};
        1: r.value = 64'($urandom_range(0, 1000));
        2: r.value = -64'($urandom_range(1, 1000));
        3: r.value = 64'd1 << k;
        4: r.value = ~(64'd1 << k);
        default: r.value = {$urandom, $urandom} >> k;
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: r.field_width = 7'($urandom_range(0, 24));
        7, 8: r.field_width = 7'($urandom_range(25, 64));
        default: r.field_width = 7'($urandom_range(65, 127));
      endcase
      case ($urandom_range(0, 4))
        0, 1: r.pad_char = CH_ZERO;
        2: r.pad_char = CH_SPACE;
        default: r.pad_char = 8'($urandom_range(0, 255));
      endcase
      r.left_align = 1'($urandom);
      r.force_sign = 1'($urandom);
      r.precision_given = ($urandom_range(0, 3) == 0);
      send_item(r);
      if (r.cmd <= CMD_BIN) counted++;
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_decimal_kinds();
    test_radix_kinds();
    test_suppressed_and_ignored();
    test_random_fields();
    start <= 1'b0;

    // Wait out the last bytes, then watch for stray output.
    while (field_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (field_bytes.size() != 0)
      log_error($sformatf("%0d expected bytes never arrived", field_bytes.size()));

    $display("Sent %0d fields over all six kinds plus %0d unknown-kind requests;",
             fields_sent, ignored_sent);
    $display("checked %0d bytes, %0d errors", bytes_checked, mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
